FILE: rtl/complex_sine_sample_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// complex sine sample generator assertion macros
// shared property wrappers clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef COMPLEX_SINE_SAMPLE_GENERATOR_UNIT_MACROS_SVH
`define COMPLEX_SINE_SAMPLE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CSSG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cssg same-cycle check failed");

// next-cycle implication
`define CSSG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cssg next-cycle check failed");

`endif

FILE: rtl/cssg_pkg.sv
// ----------------------------------------------------------------------------
// cssg_pkg
// types, constants and cordic angle table of the complex sine generator
// ----------------------------------------------------------------------------
package cssg_pkg;

  // default widths
  localparam int unsigned IndexBitsDef  = 20;
  localparam int unsigned PhaseBitsDef  = 16;
  localparam int unsigned SampleBitsDef = 16;

  // configuration register map
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned PeriodW  = 21;
  localparam int unsigned AmpW     = 15;
  localparam int unsigned OffsetW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_AMPLITUDE = 2'd1,
    CFG_PHASE     = 2'd2
  } cfg_idx_e;

  localparam logic [PeriodW-1:0] PeriodRst = 21'd16;
  localparam logic [AmpW-1:0]    AmpRst    = 15'd32767;
  localparam logic [OffsetW-1:0] OffsetRst = 16'd0;

  // cordic datapath
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicX0 = 34'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [29:0] AtanTurns [CordicSteps] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

endpackage

FILE: rtl/cssg_ifs.sv
// ----------------------------------------------------------------------------
// cssg stream interfaces
// valid/ready channels for sample requests and complex samples
// ----------------------------------------------------------------------------
interface cssg_in_if #(
  parameter int unsigned INDEX_BITS = cssg_pkg::IndexBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface cssg_out_if #(
  parameter int unsigned SAMPLE_BITS = cssg_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

FILE: rtl/complex_sine_sample_generator_unit.sv
// throughput: one transaction per cycle; the whole pipe advances when the
//   output register is empty or taken, so an output stall holds every stage
// stages: bit-serial modulo, bit-serial phase division, 30 cordic stages, multiply
// reset: valid bits clear, registers return to period 16, amplitude 32767, offset 0
// ----------------------------------------------------------------------------
// complex_sine_sample_generator_unit
// pipelined nco giving amplitude * exp(i * angle) for each sample index
// ----------------------------------------------------------------------------
module complex_sine_sample_generator_unit #(
  parameter int unsigned INDEX_BITS  = cssg_pkg::IndexBitsDef,
  parameter int unsigned PHASE_BITS  = cssg_pkg::PhaseBitsDef,
  parameter int unsigned SAMPLE_BITS = cssg_pkg::SampleBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cssg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cssg_pkg::CfgDataW-1:0]   cfg_data_i,
  cssg_in_if.sink                         in_if,
  cssg_out_if.source                      out_if
);
  import cssg_pkg::*;

  `include "complex_sine_sample_generator_unit_macros.svh"

  localparam int unsigned N  = INDEX_BITS;
  localparam int unsigned P  = PHASE_BITS;
  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned CW = CordicW;
  localparam int unsigned PW = CW + AmpW + 1;
  localparam int unsigned NS = CordicSteps;

  localparam logic signed [PW-1:0] RoundHalf = PW'(64'd1 << 29);
  localparam logic signed [PW-1:0] SatLim    = PW'((64'd1 << (S - 1)) - 64'd1);
  localparam logic signed [PW-1:0] SatLimN   = -SatLim;
  localparam logic [S-1:0]         MinCode   = S'(64'd1 << (S - 1));

  // configuration registers
  logic [PeriodW-1:0] per_q;
  logic [AmpW-1:0]    amp_q;
  logic [OffsetW-1:0] off_q;
  cfg_idx_e           cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q <= PeriodRst;
      amp_q <= AmpRst;
      off_q <= OffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        CFG_PERIOD: begin
          per_q <= (cfg_data_i[PeriodW-1:0] == '0) ? PeriodW'(1) : cfg_data_i[PeriodW-1:0];
        end
        CFG_AMPLITUDE: begin
          amp_q <= (cfg_data_i[AmpW-1:0] == '0) ? AmpW'(1) : cfg_data_i[AmpW-1:0];
        end
        CFG_PHASE: begin
          off_q <= cfg_data_i[OffsetW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic out_valid_q;
  logic adv;

  assign adv         = !out_valid_q || out_if.ready;
  assign in_if.ready = adv;

  // ---------------- modulo stages: r = n mod period ----------------
  logic               mvld_q [N+1];
  logic [N-1:0]       mn_q   [N+1];
  logic [PeriodW-1:0] mr_q   [N+1];

  // capture stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q[0] <= 1'b0;
    end else if (adv) begin
      mvld_q[0] <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mn_q[0] <= in_if.sample_index;
      mr_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_mod
    logic [PeriodW:0]   m_t;
    logic [PeriodW-1:0] m_r_d;

    // shift in one index bit, subtract period when it fits
    always_comb begin
      m_t = {mr_q[k], mn_q[k][N-1-k]};
      if (m_t >= {1'b0, per_q}) begin
        m_r_d = PeriodW'(m_t - {1'b0, per_q});
      end else begin
        m_r_d = m_t[PeriodW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mvld_q[k+1] <= 1'b0;
      end else if (adv) begin
        mvld_q[k+1] <= mvld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mn_q[k+1] <= mn_q[k];
        mr_q[k+1] <= m_r_d;
      end
    end
  end

  // ---------------- division stages: q = r * 2^P / period ----------------
  logic               dvld_q [P+1];
  logic [PeriodW-1:0] dr_q   [P+1];
  logic [P-1:0]       dq_q   [P+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q[0] <= 1'b0;
    end else if (adv) begin
      dvld_q[0] <= mvld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr_q[0] <= mr_q[N];
      dq_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < P; j++) begin : g_div
    logic [PeriodW:0]   d_t;
    logic               d_bit;
    logic [PeriodW-1:0] d_r_d;

    // one quotient bit per stage, zeros shifted in
    always_comb begin
      d_t   = {dr_q[j], 1'b0};
      d_bit = (d_t >= {1'b0, per_q});
      if (d_bit) begin
        d_r_d = PeriodW'(d_t - {1'b0, per_q});
      end else begin
        d_r_d = d_t[PeriodW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[j+1] <= 1'b0;
      end else if (adv) begin
        dvld_q[j+1] <= dvld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dr_q[j+1] <= d_r_d;
        dq_q[j+1] <= {dq_q[j][P-2:0], d_bit};
      end
    end
  end

  // ---------------- phase stage: rounding, offset add ----------------
  logic [P-1:0]     off_p;
  logic [PeriodW:0] rnd_sum;
  logic             rnd_up;
  logic [P-1:0]     ph_d;
  logic [P-1:0]     ph_q;
  logic             phv_q;

  // offset rescaled from 16 fractional bits to P
  if (P > OffsetW) begin : g_off_up
    assign off_p = {off_q, {(P - OffsetW){1'b0}}};
  end else if (P == OffsetW) begin : g_off_eq
    assign off_p = off_q;
  end else begin : g_off_dn
    assign off_p = off_q[OffsetW-1 -: P];
  end

  // final remainder plus half period decides the round-up
  always_comb begin
    rnd_sum = {1'b0, dr_q[P]} + {2'b00, per_q[PeriodW-1:1]};
    rnd_up  = (rnd_sum >= {1'b0, per_q});
    ph_d    = dq_q[P] + P'(rnd_up) + off_p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phv_q <= 1'b0;
    end else if (adv) begin
      phv_q <= dvld_q[P];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q <= ph_d;
    end
  end

  // ---------------- quadrant split and cordic ----------------
  logic [31:0] p32;
  logic [31:0] p32_bias;
  logic [1:0]  quad;
  logic [31:0] resid;

  always_comb begin
    p32      = {ph_q, {(32 - P){1'b0}}};
    p32_bias = p32 + 32'h2000_0000;
    quad     = p32_bias[31:30];
    resid    = p32 - {quad, 30'd0};
  end

  logic                 cvld_q [NS+1];
  logic signed [CW-1:0] cx_q   [NS+1];
  logic signed [CW-1:0] cy_q   [NS+1];
  logic signed [CW-1:0] cz_q   [NS+1];
  logic [1:0]           cqd_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q[0] <= 1'b0;
    end else if (adv) begin
      cvld_q[0] <= phv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0]  <= CordicX0;
      cy_q[0]  <= '0;
      cz_q[0]  <= {{(CW - 32){resid[31]}}, resid};
      cqd_q[0] <= quad;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    logic signed [CW-1:0] c_dx;
    logic signed [CW-1:0] c_dy;
    logic signed [CW-1:0] c_at;
    logic signed [CW-1:0] c_x_d;
    logic signed [CW-1:0] c_y_d;
    logic signed [CW-1:0] c_z_d;

    // rotate toward zero residual angle
    always_comb begin
      c_dx = cy_q[k] >>> k;
      c_dy = cx_q[k] >>> k;
      c_at = {{(CW - 30){1'b0}}, AtanTurns[k]};
      if (!cz_q[k][CW-1]) begin
        c_x_d = cx_q[k] - c_dx;
        c_y_d = cy_q[k] + c_dy;
        c_z_d = cz_q[k] - c_at;
      end else begin
        c_x_d = cx_q[k] + c_dx;
        c_y_d = cy_q[k] - c_dy;
        c_z_d = cz_q[k] + c_at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cvld_q[k+1] <= 1'b0;
      end else if (adv) begin
        cvld_q[k+1] <= cvld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[k+1]  <= c_x_d;
        cy_q[k+1]  <= c_y_d;
        cz_q[k+1]  <= c_z_d;
        cqd_q[k+1] <= cqd_q[k];
      end
    end
  end

  // ---------------- quadrant restore and amplitude multiply ----------------
  logic signed [CW-1:0]   rot_c;
  logic signed [CW-1:0]   rot_s;
  logic signed [AmpW:0]   amp_s;
  logic signed [PW-1:0]   prc_q;
  logic signed [PW-1:0]   prs_q;
  logic                   pv_q;

  always_comb begin
    case (cqd_q[NS])
      2'd0: begin
        rot_c = cx_q[NS];
        rot_s = cy_q[NS];
      end
      2'd1: begin
        rot_c = -cy_q[NS];
        rot_s = cx_q[NS];
      end
      2'd2: begin
        rot_c = -cx_q[NS];
        rot_s = -cy_q[NS];
      end
      default: begin
        rot_c = cy_q[NS];
        rot_s = -cx_q[NS];
      end
    endcase
    amp_s = $signed({1'b0, amp_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv) begin
      pv_q <= cvld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prc_q <= PW'(rot_c) * PW'(amp_s);
      prs_q <= PW'(rot_s) * PW'(amp_s);
    end
  end

  // ---------------- rounding, saturation, output register ----------------
  logic signed [PW-1:0] rc_t;
  logic signed [PW-1:0] rs_t;
  logic signed [PW-1:0] rc_sat;
  logic signed [PW-1:0] rs_sat;
  logic [S-1:0]         out_re_q;
  logic [S-1:0]         out_im_q;

  always_comb begin
    rc_t = (prc_q + RoundHalf) >>> 30;
    rs_t = (prs_q + RoundHalf) >>> 30;
    if (rc_t > SatLim) begin
      rc_sat = SatLim;
    end else if (rc_t < SatLimN) begin
      rc_sat = SatLimN;
    end else begin
      rc_sat = rc_t;
    end
    if (rs_t > SatLim) begin
      rs_sat = SatLim;
    end else if (rs_t < SatLimN) begin
      rs_sat = SatLimN;
    end else begin
      rs_sat = rs_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_re_q <= rc_sat[S-1:0];
      out_im_q <= rs_sat[S-1:0];
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.real_part = $signed(out_re_q);
  assign out_if.imag_part = $signed(out_im_q);

  // ---------------- assertions ----------------
  `CSSG_ASSERT_IMP(a_period_nonzero, 1'b1, per_q != '0)
  `CSSG_ASSERT_IMP(a_mod_in_range, mvld_q[N], mr_q[N] < per_q)
  `CSSG_ASSERT_NXT(a_stall_freezes_pipe, !adv, $stable(cvld_q[0]) && $stable(mvld_q[N]))
  `CSSG_ASSERT_IMP(a_out_symmetric, out_valid_q, (out_re_q != MinCode) && (out_im_q != MinCode))

endmodule
